// ----- sv/bpc_pkg.sv -----
// Shared widths, shift amounts, register indexes and stage types for the compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int RAW_W  = 24;              // raw conversion width
    localparam int CAL_W  = 16;              // calibration word width
    localparam int CFG_AW = 3;               // register index width
    localparam int DT_W   = RAW_W + 1;       // signed temperature difference
    localparam int PROD_W = DT_W + CAL_W + 1; // dT times a calibration word
    localparam int SQ_W   = 2 * DT_W;        // dT squared
    localparam int TMP_W  = 20;              // first-order temperature
    localparam int OFS_W  = 40;              // offset / sensitivity
    localparam int TOUT_W = 19;              // temperature result
    localparam int PRES_W = 32;              // pressure result

    // shift amounts of the compensation formulas
    localparam int TC_SH   = 23;
    localparam int T2_SH   = 31;
    localparam int OFF_SH  = 7;
    localparam int SENS_SH = 8;
    localparam int C2_SH   = 16;
    localparam int C1_SH   = 15;
    localparam int C5_SH   = 8;
    localparam int P1_SH   = 21;
    localparam int P2_SH   = 15;

    localparam logic signed [TMP_W-1:0] TEMP_REF   = 20'sd2000; // 20.00 C
    localparam logic signed [TMP_W-1:0] TEMP_VCOLD = 20'sd1500; // -15.00 C, negated

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_C1 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_C2 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_C3 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_C4 = 3'd3;
    localparam logic [CFG_AW-1:0] REG_C5 = 3'd4;
    localparam logic [CFG_AW-1:0] REG_C6 = 3'd5;

    localparam int NSTG = 7; // register stages, input to output

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } cal_t;

    // after the first-order temperature stage
    typedef struct packed {
        logic        [RAW_W-1:0] d1;
        logic signed [TMP_W-1:0] temp;
        logic signed [TMP_W-1:0] t2;
        logic signed [OFS_W-1:0] off_base;
        logic signed [OFS_W-1:0] sens_base;
    } s3_t;

    // after the second-order correction stage
    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic        [TOUT_W-1:0] tout;
        logic signed [OFS_W-1:0]  off;
        logic signed [OFS_W-1:0]  sens;
    } s5_t;

endpackage

`default_nettype wire

// ----- sv/bpc_front.sv -----
// Stages 1-3: temperature difference, calibration products, first-order temperature.
`timescale 1ns / 1ps
`default_nettype none

module bpc_front
    import bpc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [2:0]       en,
    input  wire cal_t             cal,
    input  wire logic [RAW_W-1:0] d1,
    input  wire logic [RAW_W-1:0] d2,
    output s3_t                   s3_reg
);

    logic        [RAW_W-1:0]  d1_s1_reg, d1_s2_reg;
    logic signed [DT_W-1:0]   dt_s1_reg, dt_next;
    logic signed [PROD_W-1:0] tc_s2_reg, offt_s2_reg, senst_s2_reg;
    logic signed [SQ_W-1:0]   sq_s2_reg;
    logic signed [PROD_W-1:0] tc_sh, offt_sh, senst_sh;
    s3_t                      s3_next;

    assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, cal.c5, C5_SH'(0)});

    always_comb begin
        tc_sh    = tc_s2_reg >>> TC_SH;
        offt_sh  = offt_s2_reg >>> OFF_SH;
        senst_sh = senst_s2_reg >>> SENS_SH;
        s3_next.d1   = d1_s2_reg;
        s3_next.temp = TEMP_REF + $signed(tc_sh[TMP_W-1:0]);
        // dT^2 is never negative, its top bits are the correction itself
        s3_next.t2   = $signed(TMP_W'(sq_s2_reg[SQ_W-1:T2_SH]));
        s3_next.off_base  = $signed(OFS_W'(cal.c2) << C2_SH) + $signed(offt_sh[OFS_W-1:0]);
        s3_next.sens_base = $signed(OFS_W'(cal.c1) << C1_SH) + $signed(senst_sh[OFS_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_s1_reg <= d1;
            dt_s1_reg <= dt_next;
        end
        if (en[1]) begin
            d1_s2_reg    <= d1_s1_reg;
            tc_s2_reg    <= dt_s1_reg * $signed({1'b0, cal.c6});
            sq_s2_reg    <= dt_s1_reg * dt_s1_reg;
            offt_s2_reg  <= dt_s1_reg * $signed({1'b0, cal.c4});
            senst_s2_reg <= dt_s1_reg * $signed({1'b0, cal.c3});
        end
        if (en[2]) begin
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bpc_second_order.sv -----
// Stages 4-5: low-temperature squares and corrected offset and sensitivity.
`timescale 1ns / 1ps
`default_nettype none

module bpc_second_order
    import bpc_pkg::*;
(
    input  wire logic [1:0] en,
    input  wire logic       aclk,
    input  wire s3_t        s3,
    output s5_t             s5_reg
);

    logic signed [TMP_W-1:0]  a, b, tout_full;
    logic        [RAW_W-1:0]  d1_s4_reg;
    logic        [TOUT_W-1:0] tout_s4_reg;
    logic signed [OFS_W-1:0]  offb_s4_reg, sensb_s4_reg, aa_s4_reg, bb_s4_reg;
    logic                     cold_s4_reg, vcold_s4_reg;
    logic signed [OFS_W-1:0]  aa5, bb7, bb11, off2, sens2;
    s5_t                      s5_next;

    assign a         = s3.temp - TEMP_REF;
    assign b         = s3.temp + TEMP_VCOLD;
    // T2 only applies on the cold side
    assign tout_full = (s3.temp < TEMP_REF) ? (s3.temp - s3.t2) : s3.temp;

    always_comb begin
        aa5  = (aa_s4_reg <<< 2) + aa_s4_reg;
        bb7  = (bb_s4_reg <<< 3) - bb_s4_reg;
        bb11 = (bb_s4_reg <<< 3) + (bb_s4_reg <<< 1) + bb_s4_reg;
        off2  = '0;
        sens2 = '0;
        if (cold_s4_reg) begin
            off2  = (aa5 >>> 1) + (vcold_s4_reg ? bb7 : OFS_W'(0));
            sens2 = (aa5 >>> 2) + (vcold_s4_reg ? (bb11 >>> 1) : OFS_W'(0));
        end
        s5_next.d1   = d1_s4_reg;
        s5_next.tout = tout_s4_reg;
        s5_next.off  = offb_s4_reg - off2;
        s5_next.sens = sensb_s4_reg - sens2;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_s4_reg    <= s3.d1;
            tout_s4_reg  <= tout_full[TOUT_W-1:0];
            offb_s4_reg  <= s3.off_base;
            sensb_s4_reg <= s3.sens_base;
            aa_s4_reg    <= a * a;
            bb_s4_reg    <= b * b;
            cold_s4_reg  <= (s3.temp < TEMP_REF);
            vcold_s4_reg <= (s3.temp < -TEMP_VCOLD);
        end
        if (en[1]) begin
            s5_reg <= s5_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bpc_pressure.sv -----
// Stages 6-7: split raw pressure times sensitivity product, then final pressure.
`timescale 1ns / 1ps
`default_nettype none

module bpc_pressure
    import bpc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [1:0]         en,
    input  wire s5_t                s5,
    output logic [TOUT_W-1:0]       tout_reg,
    output logic [PRES_W-1:0]       pres_reg
);

    localparam int SPLIT   = OFS_W / 2;
    localparam int PPLO_W  = RAW_W + SPLIT;
    localparam int PPHI_W  = RAW_W + 1 + OFS_W - SPLIT;
    localparam int FULL_W  = RAW_W + OFS_W + 2;
    localparam int DIFF_W  = P2_SH + PRES_W + 1;

    logic        [PPLO_W-1:0] pp_lo_reg;
    logic signed [PPHI_W-1:0] pp_hi_reg;
    logic signed [OFS_W-1:0]  off_s6_reg;
    logic        [TOUT_W-1:0] tout_s6_reg;
    logic signed [FULL_W-1:0] full, scaled;
    logic signed [DIFF_W-1:0] diff;

    always_comb begin
        full   = (FULL_W'(pp_hi_reg) <<< SPLIT) + $signed(FULL_W'(pp_lo_reg));
        scaled = full >>> P1_SH;
        // only bits up to the top of the result matter, so a narrow subtract is enough
        diff   = DIFF_W'(scaled) - DIFF_W'(off_s6_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pp_lo_reg   <= s5.d1 * s5.sens[SPLIT-1:0];
            pp_hi_reg   <= $signed({1'b0, s5.d1}) * $signed(s5.sens[OFS_W-1:SPLIT]);
            off_s6_reg  <= s5.off;
            tout_s6_reg <= s5.tout;
        end
        if (en[1]) begin
            tout_reg <= tout_s6_reg;
            pres_reg <= diff[P2_SH+PRES_W-1:P2_SH];
        end
    end

endmodule

`default_nettype wire

// ----- sv/barometric_pressure_compensation_top.sv -----
// Top level: calibration registers, stage handshake and the compensation pipeline.
// Throughput: one word per cycle while m_tready is high; each of the seven stages holds
// one word and a stage moves whenever the stage after it is empty or moving, so bubbles close up.
// Reset (aresetn low, synchronous): all stage valids clear, calibration words go to 0,
// s_tready is held low.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation_top
    import bpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write port
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_wr_addr,
    input  wire logic [CAL_W-1:0]  cfg_wr_data,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata   // [18:0] temperature_centi, [50:19] pressure_centi
);

    cal_t              cal_reg;
    logic [NSTG-1:0]   valid_reg;
    logic [NSTG-1:0]   en;
    logic [NSTG:0]     ready;
    s3_t               s3;
    s5_t               s5;
    logic [TOUT_W-1:0] tout;
    logic [PRES_W-1:0] pres;

    // Calibration words, unchecked: the user must write them only while the pipeline is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                REG_C1:  cal_reg.c1 <= cfg_wr_data;
                REG_C2:  cal_reg.c2 <= cfg_wr_data;
                REG_C3:  cal_reg.c3 <= cfg_wr_data;
                REG_C4:  cal_reg.c4 <= cfg_wr_data;
                REG_C5:  cal_reg.c5 <= cfg_wr_data;
                REG_C6:  cal_reg.c6 <= cfg_wr_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // Per-stage ready: a stage loads when it is empty or its word moves on.
    always_comb begin
        ready[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        en = ready[NSTG-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // no word is taken while reset is held
    assign s_tready = ready[0] && aresetn;
    assign m_tvalid = valid_reg[NSTG-1];

    // stages 1-3: dT, products with C3, C4, C6 and dT^2, first-order TEMP
    bpc_front u_front (
        .aclk   (aclk),
        .en     (en[2:0]),
        .cal    (cal_reg),
        .d1     (s_tdata[23:0]),
        .d2     (s_tdata[47:24]),
        .s3_reg (s3)
    );

    // stages 4-5: cold and very cold corrections, OFF and SENS
    bpc_second_order u_second (
        .en     (en[4:3]),
        .aclk   (aclk),
        .s3     (s3),
        .s5_reg (s5)
    );

    // stages 6-7: D1*SENS in two partial products, then the pressure
    bpc_pressure u_pressure (
        .aclk     (aclk),
        .en       (en[6:5]),
        .s5       (s5),
        .tout_reg (tout),
        .pres_reg (pres)
    );

    assign m_tdata = {5'b0, pres, tout};

endmodule

`default_nettype wire

// ----- verif/barometric_pressure_compensation_top_tb.sv -----
// Self-checking testbench for the barometric pressure compensation pipeline.
`timescale 1ns / 1ps

module barometric_pressure_compensation_top_tb;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word accepted
    localparam int RAW_MAX        = (1 << RAW_W) - 1;
    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_SET  = 62;

    // indexes past the last calibration word; writes there must be dropped
    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {WARM, COLD, VERY_COLD} regime_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_e;

    typedef struct {
        logic [RAW_W-1:0] d1;   // raw pressure
        logic [RAW_W-1:0] d2;   // raw temperature
    } raw_pair_t;

    typedef struct {
        logic signed [TOUT_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure;
        regime_e                  regime;
    } reading_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0] cfg_wr_addr = '0;
    logic [CAL_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata     = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [55:0]       m_tdata;            // [18:0] temperature_centi, [50:19] pressure_centi

    barometric_pressure_compensation_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 aclk = ~aclk;

    // local copy of the calibration words, updated as they are written
    logic [CAL_W-1:0] cal_words [6] = '{default: '0};

    raw_pair_t raw_pairs [$];         // sample pairs waiting for the driver
    reading_t  pending_readings [$];  // predicted readings, oldest first
    int        open_words  = 0;       // pairs queued but whose reading has not come back
    int        n_fail      = 0;
    int        n_results   = 0;
    int        n_cal_sets  = 0;
    int        n_regime [3] = '{default: 0};

    // Second-order compensation with the current calibration words.
    // All ">>>" act on signed 64-bit values, so they floor like the datasheet shifts.
    function automatic reading_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
        longint   d1, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, t2, off2, sens2, a, b, off, sens, p;
        reading_t r;
        d1 = d1_raw;
        c1 = cal_words[REG_C1];
        c2 = cal_words[REG_C2];
        c3 = cal_words[REG_C3];
        c4 = cal_words[REG_C4];
        c5 = cal_words[REG_C5];
        c6 = cal_words[REG_C6];
        dt    = longint'(d2_raw) - (c5 << C5_SH);
        temp  = TEMP_REF + ((dt * c6) >>> TC_SH);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        r.regime = WARM;
        if (temp < TEMP_REF) begin
            r.regime = COLD;
            a     = temp - TEMP_REF;
            t2    = (dt * dt) >>> T2_SH;
            off2  = (5 * (a * a)) >>> 1;
            sens2 = (5 * (a * a)) >>> 2;
            if (temp < -TEMP_VCOLD) begin
                r.regime = VERY_COLD;
                b      = temp + TEMP_VCOLD;
                off2  += 7 * (b * b);
                sens2 += (11 * (b * b)) >>> 1;
            end
        end
        off  = (c2 << C2_SH) + ((c4 * dt) >>> OFF_SH) - off2;
        sens = (c1 << C1_SH) + ((c3 * dt) >>> SENS_SH) - sens2;
        p    = (((d1 * sens) >>> P1_SH) - off) >>> P2_SH;
        r.temperature = TOUT_W'(temp - t2);
        r.pressure    = PRES_W'(p);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them.
    // The reading is predicted at the edge where the word is taken.
    // ---------------------------------------------------------------
    raw_pair_t on_bus;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_readings.push_back(compensate(on_bus.d1, on_bus.d2));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (raw_pairs.size() > 0) begin
                    on_bus = raw_pairs.pop_front();
                    s_tdata  <= {on_bus.d2, on_bus.d1};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // a quarter of the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: backpressure mode changes at random intervals.
    // ---------------------------------------------------------------
    rx_mode_e   rx_mode  = RX_OPEN;
    int         rx_left  = 0;
    logic [2:0] rx_count = '0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        rx_count <= rx_count + 1'b1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_count[1:0] == 2'd0);
            default:   m_tready <= (rx_count != 3'd5);   // low only when the counter reads 5
        endcase
    end

    // ---------------------------------------------------------------
    // Monitor: each result word against the oldest prediction.
    // ---------------------------------------------------------------
    reading_t                 want;
    logic signed [TOUT_W-1:0] got_temp;
    logic signed [PRES_W-1:0] got_pres;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_temp = m_tdata[TOUT_W-1:0];
            got_pres = m_tdata[TOUT_W +: PRES_W];
            if (pending_readings.size() == 0) begin
                $error("result word %h with no reading pending", m_tdata);
                n_fail++;
            end else begin
                want = pending_readings.pop_front();
                open_words--;
                n_results++;
                n_regime[want.regime]++;
                if (got_temp !== want.temperature) begin
                    $error("temperature_centi: expected %0d, got %0d", want.temperature, got_temp);
                    n_fail++;
                end
                if (got_pres !== want.pressure) begin
                    $error("pressure_centi: expected %0d, got %0d", want.pressure, got_pres);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles with no word accepted, %0d readings outstanding",
                     idle_cycles, open_words);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_pair(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        raw_pair_t w;
        w.d1 = d1;
        w.d2 = d2;
        open_words++;
        raw_pairs.push_back(w);
    endtask

    // Hold off the sender until every reading is back and the pipe has drained.
    task automatic wait_drained();
        while (open_words != 0)
            @(posedge aclk);
        repeat (NSTG) @(posedge aclk);
    endtask

    task automatic write_cal(logic [CFG_AW-1:0] idx, logic [CAL_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx <= REG_C6)
            cal_words[idx] = value;
    endtask

    task automatic load_cal(logic [CAL_W-1:0] c1, logic [CAL_W-1:0] c2, logic [CAL_W-1:0] c3,
                            logic [CAL_W-1:0] c4, logic [CAL_W-1:0] c5, logic [CAL_W-1:0] c6);
        write_cal(REG_C1, c1);
        write_cal(REG_C2, c2);
        write_cal(REG_C3, c3);
        write_cal(REG_C4, c4);
        write_cal(REG_C5, c5);
        write_cal(REG_C6, c6);
        n_cal_sets++;
    endtask

    function automatic logic [CAL_W-1:0] pick_word(bit with_extremes);
        if (with_extremes) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                default: return CAL_W'($urandom_range(0, 16'hFFFF));
            endcase
        end
        return CAL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int center, span, v;
        logic [RAW_W-1:0] d1, d2;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calibration still at reset: everything collapses to 20.00 C, zero pressure
        n_cal_sets++;
        push_pair('0, '0);
        push_pair('1, '1);
        push_pair('1, '0);
        wait_drained();

        // C5 = C6 = 2^15 gives TEMP = 2000 + floor((D2 - 2^23) / 256),
        // which lets the warm/cold and cold/very-cold edges be hit exactly
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768);
        write_cal(REG_SPARE_LO, 16'hA5A5);   // must not land anywhere
        write_cal(REG_SPARE_HI, 16'hFFFF);
        push_pair(24'd9085466, 24'd8388608);  // exactly 20.00 C, warm
        push_pair(24'd9085466, 24'd8388607);  // 19.99 C, just cold
        push_pair('1,          24'd7492608);  // exactly -15.00 C, cold only
        push_pair('0,          24'd7492607);  // -15.01 C, very cold
        push_pair('1,          '0);           // coldest reachable here
        push_pair('0,          '1);           // hottest reachable here
        wait_drained();

        // typical factory words
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        push_pair(24'd9085466, 24'd8569150);
        push_pair('0, 24'd8569150);
        push_pair('1, 24'd8569150);
        push_pair(24'd9085466, '0);
        push_pair(24'd9085466, '1);
        push_pair('1, '0);
        wait_drained();

        // every word at its maximum
        load_cal('1, '1, '1, '1, '1, '1);
        push_pair('0, '0);
        push_pair('1, '0);
        push_pair('0, '1);
        push_pair('1, '1);
        push_pair(24'h800000, 24'h7FFFFF);
        wait_drained();

        // random calibration sets; the later ones mix in all-zero and all-one words
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_cal(pick_word(ph >= 3), pick_word(ph >= 3), pick_word(ph >= 3),
                     pick_word(ph >= 3), pick_word(ph >= 3), pick_word(ph >= 3));
            center = int'(cal_words[REG_C5]) << C5_SH;
            for (int k = 0; k < WORDS_PER_SET; k++) begin
                case ($urandom_range(0, 15))
                    0:       d1 = '0;
                    1:       d1 = '1;
                    default: d1 = RAW_W'($urandom_range(0, RAW_MAX));
                endcase
                // half the pairs sit near the reference temperature, where the
                // cold-side terms switch on at varying distances
                if ($urandom_range(0, 1)) begin
                    span = 1 << $urandom_range(6, 22);
                    v    = center + int'($urandom_range(0, 2 * span)) - span;
                    if (v < 0)
                        v = 0;
                    else if (v > RAW_MAX)
                        v = RAW_MAX;
                    d2 = RAW_W'(v);
                end else begin
                    d2 = RAW_W'($urandom_range(0, RAW_MAX));
                end
                push_pair(d1, d2);
            end
            wait_drained();
        end

        repeat (4 * NSTG) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $error("%0d predicted readings never came out", pending_readings.size());
            n_fail++;
        end

        $display("checked %0d readings over %0d calibration sets", n_results, n_cal_sets);
        $display("regimes seen: %0d warm, %0d cold, %0d very cold; %0d mismatches",
                 n_regime[WARM], n_regime[COLD], n_regime[VERY_COLD], n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
